// ===== design/relocation_bitmap_finder_assert.svh =====
// ----------------------------------------------------------------------------
// Relocation bitmap finder assertion macros
// Concurrent assertion wrappers clocked on aclk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RELOCATION_BITMAP_FINDER_ASSERT_SVH
`define RELOCATION_BITMAP_FINDER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RBF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define RBF_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define RBF_ASSERT(label, prop, msg)
`define RBF_ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ===== design/rbf_pkg.sv =====
// ----------------------------------------------------------------------------
// Relocation bitmap finder package
// Transaction payload types and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package rbf_pkg;

    localparam int unsigned OFFSET_W = 20;
    localparam int unsigned MARK_W   = 18;
    localparam logic [MARK_W-1:0] MARK_MAX = '1;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       last_byte;
    } rbf_in_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset_index;
        logic                mark;
        logic                failed;
        logic                final_res;
        logic [MARK_W-1:0]   mark_total;
    } rbf_out_t;

    // classified offset handed from front to back
    typedef struct packed {
        logic is_zero;
        logic hit;
        logic is_final;
        logic pad_hit;
    } rbf_entry_t;

endpackage

`default_nettype wire

// ===== design/rbf_front.sv =====
// ----------------------------------------------------------------------------
// Relocation bitmap finder front end
// Shifts byte pairs into the look-ahead windows, forms the cell difference
// and classifies each decided offset into a queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_front #(
    parameter int unsigned CELL_BYTES = 8
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_valid,
    output logic                      s_ready,
    input  rbf_pkg::rbf_in_t          s_data,
    input  wire  [8*CELL_BYTES-1:0]   delta_cell,
    output logic                      push_valid,
    input  wire                       push_ready,
    output rbf_pkg::rbf_entry_t       push_data
);

    localparam int unsigned CW    = 8 * CELL_BYTES;
    localparam int unsigned CNT_W = $clog2(CELL_BYTES);
    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(CELL_BYTES - 1);
    localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

    logic [7:0]       win_first_reg  [CELL_BYTES];
    logic [7:0]       win_second_reg [CELL_BYTES];
    logic [CNT_W-1:0] prime_reg, prime_next;
    logic [CNT_W-1:0] flush_cnt_reg, flush_cnt_next;
    logic             flush_reg, flush_next;
    logic             pend_reg, pend_next;
    logic             pend_final_reg, pend_final_next;

    logic          adv, take, vstep, step, emit_now, final_now;
    logic [7:0]    byte_a, byte_b;
    logic [CW-1:0] cell_first, cell_second, diff;

    assign adv      = !pend_reg || push_ready;
    assign s_ready  = adv && !flush_reg;
    assign take     = s_valid && s_ready;
    assign vstep    = flush_reg && adv;
    assign step     = take || vstep;
    assign emit_now = (prime_reg == LAST_POS);
    assign final_now = vstep && (flush_cnt_reg == ONE);
    assign byte_a   = flush_reg ? 8'd0 : s_data.first_byte;
    assign byte_b   = flush_reg ? 8'd0 : s_data.second_byte;

    always_comb begin
        for (int i = 0; i < CELL_BYTES; i++) begin
            cell_first[8*i +: 8]  = win_first_reg[i];
            cell_second[8*i +: 8] = win_second_reg[i];
        end
    end

    assign diff = cell_second - cell_first;

    assign push_valid         = pend_reg;
    assign push_data.is_zero  = (diff == '0);
    assign push_data.hit      = (diff == delta_cell);
    assign push_data.is_final = pend_final_reg;
    assign push_data.pad_hit  = (delta_cell == '0);

    always_comb begin
        prime_next      = prime_reg;
        flush_next      = flush_reg;
        flush_cnt_next  = flush_cnt_reg;
        pend_next       = pend_reg;
        pend_final_next = pend_final_reg;
        if (adv) begin
            pend_next       = step && emit_now;
            pend_final_next = final_now;
        end
        if (step && !emit_now) begin
            prime_next = prime_reg + ONE;
        end
        if (take && s_data.last_byte) begin
            flush_next     = 1'b1;
            flush_cnt_next = LAST_POS;
        end
        if (vstep) begin
            flush_cnt_next = flush_cnt_reg - ONE;
            if (final_now) begin
                flush_next = 1'b0;
                prime_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prime_reg      <= '0;
            flush_reg      <= 1'b0;
            flush_cnt_reg  <= '0;
            pend_reg       <= 1'b0;
            pend_final_reg <= 1'b0;
        end else begin
            prime_reg      <= prime_next;
            flush_reg      <= flush_next;
            flush_cnt_reg  <= flush_cnt_next;
            pend_reg       <= pend_next;
            pend_final_reg <= pend_final_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            for (int i = 0; i < CELL_BYTES - 1; i++) begin
                win_first_reg[i]  <= win_first_reg[i+1];
                win_second_reg[i] <= win_second_reg[i+1];
            end
            win_first_reg[CELL_BYTES-1]  <= byte_a;
            win_second_reg[CELL_BYTES-1] <= byte_b;
        end
    end

endmodule

`default_nettype wire

// ===== design/rbf_queue.sv =====
// ----------------------------------------------------------------------------
// Relocation bitmap finder queue
// Small register queue of classified offsets between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "relocation_bitmap_finder_assert.svh"

module rbf_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  push_valid,
    output logic                 push_ready,
    input  rbf_pkg::rbf_entry_t  push_data,
    output logic                 pop_valid,
    input  wire                  pop_ready,
    output rbf_pkg::rbf_entry_t  pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    rbf_pkg::rbf_entry_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `RBF_ASSERT_NEVER(a_count_bound, count_reg > CNT_FULL, "queue count past depth")

endmodule

`default_nettype wire

// ===== design/rbf_back.sv =====
// ----------------------------------------------------------------------------
// Relocation bitmap finder back end
// Runs the skip and search decision per offset, keeps offset and mark counts
// and the fail flag, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "relocation_bitmap_finder_assert.svh"

module rbf_back #(
    parameter int unsigned CELL_BYTES      = 8,
    parameter int unsigned MAX_IMAGE_BYTES = 1048576
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  pop_valid,
    output logic                 pop_ready,
    input  rbf_pkg::rbf_entry_t  pop_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output rbf_pkg::rbf_out_t    m_data
);

    localparam int unsigned CNT_W = $clog2(CELL_BYTES);
    localparam int unsigned OFF_W = $clog2(MAX_IMAGE_BYTES);
    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(CELL_BYTES - 1);
    localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(MAX_IMAGE_BYTES - 1);

    logic [CNT_W-1:0]            skip_reg, skip_next;
    logic [CNT_W-1:0]            search_reg, search_next;
    logic                        fail_reg, fail_next;
    logic [OFF_W-1:0]            off_reg, off_next;
    logic [rbf_pkg::MARK_W-1:0]  mark_cnt_reg, mark_cnt_next;
    logic                        out_valid_reg, out_valid_next;
    rbf_pkg::rbf_out_t           out_reg;

    logic                                take, mark;
    logic [rbf_pkg::MARK_W-1:0]          mark_inc;
    logic [OFF_W-1:0]                    off_inc;
    logic [OFF_W+rbf_pkg::OFFSET_W-1:0]  off_ext;

    assign pop_ready = !out_valid_reg || m_ready;
    assign take      = pop_valid && pop_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        skip_next   = skip_reg;
        search_next = search_reg;
        fail_next   = fail_reg;
        mark        = 1'b0;
        priority if (skip_reg != '0) begin
            skip_next = skip_reg - CNT_W'(1);
        end else if (search_reg != '0) begin
            if (pop_data.hit) begin
                search_next = '0;
                skip_next   = LAST_POS;
                mark        = 1'b1;
            end else if (search_reg == LAST_POS) begin
                search_next = '0;
                fail_next   = 1'b1;
            end else begin
                search_next = search_reg + CNT_W'(1);
            end
        end else if (!pop_data.is_zero) begin
            if (pop_data.hit) begin
                skip_next = LAST_POS;
                mark      = 1'b1;
            end else begin
                search_next = CNT_W'(1);
            end
        end else begin
            mark = 1'b0;
        end
    end

    assign mark_inc = (mark && (mark_cnt_reg != rbf_pkg::MARK_MAX)) ?
                      mark_cnt_reg + rbf_pkg::MARK_W'(1) : mark_cnt_reg;
    assign off_inc  = (off_reg == OFF_LAST) ? '0 : off_reg + OFF_W'(1);
    assign off_ext  = {{rbf_pkg::OFFSET_W{1'b0}}, off_reg};

    always_comb begin
        out_valid_next = out_valid_reg;
        off_next       = off_reg;
        mark_cnt_next  = mark_cnt_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (take) begin
            out_valid_next = 1'b1;
            off_next       = off_inc;
            mark_cnt_next  = mark_inc;
            if (pop_data.is_final) begin
                off_next      = '0;
                mark_cnt_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg      <= '0;
            search_reg    <= '0;
            fail_reg      <= 1'b0;
            off_reg       <= '0;
            mark_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            off_reg       <= off_next;
            mark_cnt_reg  <= mark_cnt_next;
            if (take) begin
                if (pop_data.is_final) begin
                    skip_reg   <= '0;
                    search_reg <= '0;
                    fail_reg   <= 1'b0;
                end else begin
                    skip_reg   <= skip_next;
                    search_reg <= search_next;
                    fail_reg   <= fail_next;
                end
            end
        end
    end

    // trailing search on the final offset runs over zero cells only
    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg.offset_index <= off_ext[rbf_pkg::OFFSET_W-1:0];
            out_reg.mark         <= mark;
            out_reg.failed       <= fail_next || (pop_data.is_final &&
                                    (search_next != '0) && !pop_data.pad_hit);
            out_reg.final_res    <= pop_data.is_final;
            out_reg.mark_total   <= mark_inc;
        end
    end

    `RBF_ASSERT_NEVER(a_skip_search_excl, (skip_reg != '0) && (search_reg != '0), "skip and search both active")
    `RBF_ASSERT(a_final_clears, take && pop_data.is_final |=> (off_reg == '0) && (mark_cnt_reg == '0) && !fail_reg, "state not cleared after final offset")
    `RBF_ASSERT(a_mark_counted, m_valid && m_data.mark |-> m_data.mark_total != '0, "mark without count")

endmodule

`default_nettype wire

// ===== design/relocation_bitmap_finder.sv =====
// ----------------------------------------------------------------------------
// Relocation bitmap finder
// Takes one byte pair a cycle when not stalled from two images and gives one
// relocation mark per offset, with running mark count and sticky fail flag.
// ----------------------------------------------------------------------------
// Throughput is one byte pair per cycle when not stalled; the cell subtract
// and compare run in one front-end stage. Results for an offset appear
// CELL_BYTES-1 transactions after its byte, via pend_reg, the queue and
// out_reg. The last_byte transaction makes the front end shift in
// CELL_BYTES-1 zero byte pairs, one per cycle unless stalled, to flush the
// window, with s_ready low. A four-entry queue separates the classifier
// from the decision logic. Write delta only while the block is idle.
`default_nettype none

module relocation_bitmap_finder #(
    parameter int unsigned CELL_BYTES      = 8,
    parameter int unsigned MAX_IMAGE_BYTES = 1048576
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  rbf_pkg::rbf_in_t    s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output rbf_pkg::rbf_out_t   m_data,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire signed [63:0]   cfg_delta
);

    localparam int unsigned CW          = 8 * CELL_BYTES;
    localparam int unsigned QUEUE_DEPTH = 4;

    logic signed [63:0]   delta_reg;
    logic                 push_valid, push_ready, pop_valid, pop_ready;
    rbf_pkg::rbf_entry_t  push_data, pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delta_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            delta_reg <= cfg_delta;
        end
    end

    rbf_front #(
        .CELL_BYTES (CELL_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .delta_cell (delta_reg[CW-1:0]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rbf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rbf_back #(
        .CELL_BYTES      (CELL_BYTES),
        .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ===== sim/tb_relocation_bitmap_finder.sv =====
// ----------------------------------------------------------------------------
// Relocation bitmap finder testbench
// Streams pairs of images through the block with random valid and ready
// gaps. A scoreboard predicts the per-offset relocation marks, the running
// mark count and the sticky fail flag, then checks each result transaction.
// The delta register is changed between images, with its extremes included.
// ----------------------------------------------------------------------------
`default_nettype none

localparam int CELL = 8;
localparam int unsigned MAX_IMAGE = 1048576;

class reloc_marks;
    bit [63:0]                delta;
    bit [7:0]                 win_a [CELL];
    bit [7:0]                 win_b [CELL];
    int unsigned              held;
    int unsigned              hunt;
    int unsigned              skip_left;
    int unsigned              next_offset;
    bit [rbf_pkg::MARK_W-1:0] marks;
    bit                       sticky_fail;
    rbf_pkg::rbf_out_t        pending_marks [$];
    int unsigned              errors;

    function new();
        delta = '0;
        errors = 0;
        clear_image();
    endfunction

    function void clear_image();
        int i;
        for (i = 0; i < CELL; i++) begin
            win_a[i] = '0;
            win_b[i] = '0;
        end
        held = 0;
        hunt = 0;
        skip_left = 0;
        next_offset = 0;
        marks = '0;
        sticky_fail = 1'b0;
    endfunction

    function void shift_pair(bit [7:0] a, bit [7:0] b);
        int i;
        for (i = 0; i < CELL - 1; i++) begin
            win_a[i] = win_a[i+1];
            win_b[i] = win_b[i+1];
        end
        win_a[CELL-1] = a;
        win_b[CELL-1] = b;
    endfunction

    function bit decide_mark();
        bit [63:0] ca;
        bit [63:0] cb;
        bit [63:0] diff;
        bit        hit;
        int        i;
        ca = '0;
        cb = '0;
        for (i = CELL - 1; i >= 0; i--) begin
            ca = {ca[55:0], win_a[i]};
            cb = {cb[55:0], win_b[i]};
        end
        diff = cb - ca;
        hit = (diff == delta);
        if (skip_left > 0) begin
            skip_left--;
            return 1'b0;
        end
        if (hunt > 0) begin
            if (hit) begin
                hunt = 0;
                skip_left = CELL - 1;
                return 1'b1;
            end
            if (hunt + 1 >= CELL) begin
                hunt = 0;
                sticky_fail = 1'b1;
            end else begin
                hunt++;
            end
            return 1'b0;
        end
        if (diff == '0)
            return 1'b0;
        if (hit) begin
            skip_left = CELL - 1;
            return 1'b1;
        end
        hunt = 1;
        return 1'b0;
    endfunction

    function void emit_mark(bit m);
        rbf_pkg::rbf_out_t r;
        if (m && marks != rbf_pkg::MARK_MAX)
            marks++;
        r.offset_index = next_offset[rbf_pkg::OFFSET_W-1:0];
        r.mark = m;
        r.failed = sticky_fail;
        r.final_res = 1'b0;
        r.mark_total = marks;
        pending_marks.push_back(r);
        next_offset = (next_offset + 1 >= MAX_IMAGE) ? 0 : next_offset + 1;
    endfunction

    function void take_pair(rbf_pkg::rbf_in_t it);
        int                produced;
        int                fill;
        int                i;
        rbf_pkg::rbf_out_t r;
        produced = 0;
        shift_pair(it.first_byte, it.second_byte);
        if (held >= CELL - 1) begin
            emit_mark(decide_mark());
            produced++;
        end else begin
            held++;
        end
        if (it.last_byte) begin
            fill = held;
            for (i = 0; i + fill + 1 < CELL; i++)
                shift_pair(8'h00, 8'h00);
            for (i = 0; i < fill; i++) begin
                shift_pair(8'h00, 8'h00);
                emit_mark(decide_mark());
                produced++;
            end
            // search past the end resolves silently
            while (hunt > 0) begin
                shift_pair(8'h00, 8'h00);
                void'(decide_mark());
            end
            if (produced > 0) begin
                r = pending_marks.pop_back();
                r.failed = sticky_fail;
                r.final_res = 1'b1;
                pending_marks.push_back(r);
            end
            clear_image();
        end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function void check_mark(rbf_pkg::rbf_out_t got);
        rbf_pkg::rbf_out_t want;
        if (pending_marks.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual offset %0d mark %0d",
                     $time, got.offset_index, got.mark);
        end else begin
            want = pending_marks.pop_front();
            compare_field("offset_index", 32'(want.offset_index), 32'(got.offset_index));
            compare_field("mark", 32'(want.mark), 32'(got.mark));
            compare_field("failed", 32'(want.failed), 32'(got.failed));
            compare_field("final_res", 32'(want.final_res), 32'(got.final_res));
            compare_field("mark_total", 32'(want.mark_total), 32'(got.mark_total));
        end
    endfunction
endclass

module tb_relocation_bitmap_finder;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE = 32;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    rbf_pkg::rbf_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    rbf_pkg::rbf_out_t m_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [63:0]       cfg_delta = '0;

    bit          quiet = 1'b0;
    int          stall_cycles = 0;
    reloc_marks  board = new();
    bit [7:0]    img_a [];
    bit [7:0]    img_b [];

    relocation_bitmap_finder #(
        .CELL_BYTES      (CELL),
        .MAX_IMAGE_BYTES (MAX_IMAGE)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_delta (cfg_delta)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)
                || (cfg_valid && cfg_ready === 1'b1)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        int gap;
        @(posedge aclk);
        forever begin
            gap = quiet ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            board.check_mark(m_data);
        end
    end

    task automatic send_pair(rbf_pkg::rbf_in_t it, bit hold);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (hold || gap > 0) begin
            s_valid <= 1'b0;
            if (hold)
                do @(posedge aclk); while (board.pending_marks.size() != 0);
            repeat (gap) @(posedge aclk);
        end
        s_data <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        board.take_pair(it);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending_marks.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_delta(logic [63:0] value);
        settle();
        cfg_delta <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        board.delta = value;
    endtask

    task automatic run_image(int len, int nreloc, int nnoise, bit scramble, int drain_at);
        rbf_pkg::rbf_in_t it;
        bit [63:0]        c;
        int               o;
        int               n;
        int               p;
        int               j;
        int               fill_mode;
        img_a = new[len];
        img_b = new[len];
        fill_mode = $urandom_range(0, 5);
        for (p = 0; p < len; p++) begin
            img_a[p] = (fill_mode == 0) ? 8'h00 : (fill_mode == 1) ? 8'hFF
                     : 8'($urandom_range(0, 255));
            img_b[p] = scramble ? 8'($urandom_range(0, 255)) : img_a[p];
        end
        // relocated cells, spaced at least one cell apart
        o = $urandom_range(0, 3);
        n = 0;
        while (o < len && n < nreloc) begin
            c = '0;
            for (j = CELL - 1; j >= 0; j--)
                c = {c[55:0], (o + j < len) ? img_b[o+j] : 8'h00};
            c = c + board.delta;
            for (j = 0; j < CELL; j++)
                if (o + j < len)
                    img_b[o+j] = c[8*j +: 8];
            n++;
            o += CELL + $urandom_range(0, 6);
        end
        for (n = 0; n < nnoise; n++) begin
            p = $urandom_range(0, len - 1);
            img_b[p] ^= 8'($urandom_range(1, 255));
        end
        for (p = 0; p < len; p++) begin
            it.first_byte = img_a[p];
            it.second_byte = img_b[p];
            it.last_byte = (p == len - 1);
            send_pair(it, p == drain_at);
        end
    endtask

    initial begin
        rbf_pkg::rbf_in_t it;
        logic [63:0]      deltas [6];
        int               k;
        int               len;
        int               phase_items;

        deltas[0] = 64'h0000_0000_0000_0001;
        deltas[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        deltas[2] = 64'h7FFF_FFFF_FFFF_FFFF;
        deltas[3] = 64'h8000_0000_0000_0000;
        deltas[4] = {$urandom, $urandom};
        deltas[5] = 64'($urandom_range(1, 65535));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // delta at reset is zero: one-byte images, then a difference that never matches
        it.first_byte = 8'h00;
        it.second_byte = 8'h00;
        it.last_byte = 1'b1;
        send_pair(it, 1'b0);
        it.first_byte = 8'hFF;
        it.second_byte = 8'h00;
        send_pair(it, 1'b0);
        it.first_byte = 8'hFF;
        it.second_byte = 8'hFF;
        it.last_byte = 1'b0;
        send_pair(it, 1'b0);
        it.first_byte = 8'hAA;
        it.second_byte = 8'hAA;
        send_pair(it, 1'b0);
        it.first_byte = 8'h55;
        it.second_byte = 8'h55;
        it.last_byte = 1'b1;
        send_pair(it, 1'b0);

        write_delta(64'h0000_0100_0000_0040);
        run_image(16, 2, 1, 1'b0, 9);

        for (k = 0; k < 6; k++) begin
            write_delta(deltas[k]);
            phase_items = 0;
            while (phase_items < 18) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7)
                    : $urandom_range(8, 24);
                quiet = ($urandom_range(0, 3) == 0);
                run_image(len, $urandom_range(0, 3),
                          ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0,
                          $urandom_range(0, 7) == 0,
                          ($urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : -1);
                phase_items += len;
            end
        end
        quiet = 1'b0;

        settle();
        if (board.errors == 0 && board.pending_marks.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== relocation_bitmap_finder.f =====
+incdir+design
design/rbf_pkg.sv
design/rbf_front.sv
design/rbf_queue.sv
design/rbf_back.sv
design/relocation_bitmap_finder.sv
sim/tb_relocation_bitmap_finder.sv
